[rtl/core/wpsd_pkg.sv]
// Package for the WAV PCM stream decoder: parse phases, chunk tags, status codes,
// format defaults and the result record shared by the parser, the result queue and the top.
// No dependencies.
package wpsd_pkg;

	typedef enum logic [6:0] {
		PH_HDR  = 7'b0000001,
		PH_CHDR = 7'b0000010,
		PH_FMT  = 7'b0000100,
		PH_SKIP = 7'b0001000,
		PH_DATA = 7'b0010000,
		PH_PAD  = 7'b0100000,
		PH_ERR  = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		CT_OTHER = 2'd0,
		CT_FMT   = 2'd1,
		CT_DATA  = 2'd2
	} chunk_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
	localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
	localparam logic [2:0] ST_NO_DATA   = 3'd3;
	localparam logic [2:0] ST_BAD_DEPTH = 3'd4;
	localparam logic [2:0] ST_ZERO_FRM  = 3'd5;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [15:0] DEF_CHANNELS = 16'd1;
	localparam logic [15:0] DEF_BITS     = 16'd16;
	localparam logic [31:0] DEF_RATE     = 32'd44100;

	localparam int FS_W = 29;
	localparam logic [FS_W-1:0] DEF_FRAME = FS_W'(2);

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic               kind;
		logic signed [16:0] sample;
		logic [2:0]         status;
		logic [31:0]        rate;
		logic [15:0]        channels;
		logic [15:0]        bits;
		logic               last;
	} res_t;

	typedef struct packed {
		logic p0;
		logic p1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

[rtl/core/wpsd_parser.sv]
// Byte-level RIFF/WAVE chunk parser: header checks, chunk walk, fmt capture,
// frame assembly and sample/status result generation. Depends on wpsd_pkg.
module wpsd_parser import wpsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output push_t      push
);

	phase_t          ph_q, ph_u, ph_d;
	logic [4:0]      off_q, off_u, off_d;
	logic [31:0]     word_q, word_u, word_d;
	chunk_t          ctype_q, ctype_u, ctype_d;
	logic [31:0]     left_q, left_u, left_d;
	logic            pad_q, pad_u, pad_d;
	logic [15:0]     ch_q, ch_u, ch_d;
	logic [15:0]     bits_q, bits_u, bits_d;
	logic [31:0]     rate_q, rate_u, rate_d;
	logic            found_q, found_u, found_d;
	logic [17:0]     idx_q, idx_u, idx_d;
	logic [15:0]     first_q, first_u, first_d;
	logic [15:0]     second_q, second_u, second_d;
	logic [2:0]      err_q, err_u, err_d;
	logic [FS_W-1:0] fs_q, fs_prod;

	logic [31:0]        word_sh, left_dec;
	logic [4:0]         off_inc;
	logic [18:0]        idx_inc;
	logic               wide, stereo, good, smp_v;
	logic signed [16:0] smp;
	logic signed [16:0] l17, r17;
	logic signed [9:0]  ln10, rn10, sum10;
	logic [2:0]         st;
	res_t               smp_res, st_res;

	assign fs_prod = FS_W'(ch_q) * FS_W'(bits_q[15:3]);
	assign word_sh = {in_byte, word_q[31:8]};
	assign off_inc = off_q + 5'd1;
	assign left_dec = left_q - 32'd1;
	assign idx_inc = {1'b0, idx_q} + 19'd1;
	assign wide = (bits_q == 16'd16);
	assign stereo = (ch_q == 16'd2);
	assign good = (bits_q == 16'd8) || wide;

	always_comb begin
		ph_u = ph_q;
		off_u = off_q;
		word_u = word_q;
		ctype_u = ctype_q;
		left_u = left_q;
		pad_u = pad_q;
		ch_u = ch_q;
		bits_u = bits_q;
		rate_u = rate_q;
		found_u = found_q;
		idx_u = idx_q;
		first_u = first_q;
		second_u = second_q;
		err_u = err_q;
		smp_v = 1'b0;
		case (ph_q)
			PH_HDR: begin
				word_u = word_sh;
				off_u = off_inc;
				if (off_inc == 5'd4 && word_sh != TAG_RIFF) begin
					err_u = ST_NOT_RIFF;
					ph_u = PH_ERR;
				end else if (off_inc == 5'd12) begin
					if (word_sh != TAG_WAVE) begin
						err_u = ST_NOT_WAVE;
						ph_u = PH_ERR;
					end else begin
						ph_u = PH_CHDR;
						off_u = '0;
						word_u = '0;
					end
				end
			end
			PH_CHDR: begin
				word_u = word_sh;
				off_u = off_inc;
				if (off_inc == 5'd4) begin
					ctype_u = (word_sh == TAG_FMT) ? CT_FMT :
						(word_sh == TAG_DATA) ? CT_DATA : CT_OTHER;
				end else if (off_inc >= 5'd8) begin
					left_u = word_sh;
					pad_u = word_sh[0];
					off_u = '0;
					ph_u = PH_SKIP;
					if (word_sh == '0) begin
						ph_u = PH_CHDR;
						word_u = '0;
					end else if (ctype_q == CT_FMT) begin
						if (!found_q && word_sh >= 32'd16) ph_u = PH_FMT;
					end else if (ctype_q == CT_DATA && !found_q) begin
						if (fs_q == '0) begin
							err_u = ST_ZERO_FRM;
							ph_u = PH_ERR;
						end else if (!good && word_sh >= {3'b000, fs_q}) begin
							err_u = ST_BAD_DEPTH;
							ph_u = PH_ERR;
						end else begin
							found_u = 1'b1;
							if (good) begin
								ph_u = PH_DATA;
								idx_u = '0;
							end
						end
					end
				end
			end
			PH_FMT, PH_SKIP, PH_DATA: begin
				if (ph_q == PH_FMT) begin
					case (off_q)
						5'd2: ch_u = {8'h00, in_byte};
						5'd3: ch_u[15:8] = in_byte;
						5'd4: rate_u = {24'h0, in_byte};
						5'd5: rate_u[15:8] = in_byte;
						5'd6: rate_u[23:16] = in_byte;
						5'd7: rate_u[31:24] = in_byte;
						5'd14: bits_u = {8'h00, in_byte};
						5'd15: bits_u[15:8] = in_byte;
						default: ;
					endcase
					if (off_q < 5'd16) off_u = off_inc;
				end else if (ph_q == PH_DATA) begin
					if (wide) begin
						if (idx_q == 18'd0) first_u = {8'h00, in_byte};
						else if (idx_q == 18'd1) first_u[15:8] = in_byte;
						else if (idx_q == 18'd2) second_u = {8'h00, in_byte};
						else if (idx_q == 18'd3) second_u[15:8] = in_byte;
					end else begin
						if (idx_q == 18'd0) first_u = {8'h00, in_byte};
						else if (idx_q == 18'd1) second_u = {8'h00, in_byte};
					end
					if ({10'b0, idx_inc} < fs_q) begin
						idx_u = idx_inc[17:0];
					end else begin
						idx_u = '0;
						smp_v = 1'b1;
					end
				end
				left_u = left_dec;
				if (left_dec == '0) begin
					ph_u = pad_q ? PH_PAD : PH_CHDR;
					off_u = '0;
					word_u = '0;
				end
			end
			PH_PAD: begin
				ph_u = PH_CHDR;
				off_u = '0;
				word_u = '0;
			end
			default: ;
		endcase
	end

	// sample from the frame values including this byte
	always_comb begin
		l17 = {first_u[15], first_u};
		r17 = {second_u[15], second_u};
		ln10 = $signed({2'b00, first_u[7:0]}) - 10'sd128;
		rn10 = $signed({2'b00, second_u[7:0]}) - 10'sd128;
		sum10 = ln10 + rn10;
		if (wide) smp = stereo ? (l17 + r17) : {first_u, 1'b0};
		else smp = stereo ? {sum10[8:0], 8'h00} : {ln10[7:0], 9'h000};
	end

	always_comb begin
		if (err_u != ST_OK) st = err_u;
		else if (ph_u == PH_HDR) st = (off_u < 5'd4) ? ST_NOT_RIFF : ST_NOT_WAVE;
		else if (!found_u) st = ST_NO_DATA;
		else st = ST_OK;
	end

	always_comb begin
		smp_res = '{kind: KIND_SAMPLE, sample: smp, status: ST_OK, rate: rate_u,
			channels: ch_u, bits: bits_u, last: 1'b0};
		st_res = '{kind: KIND_STATUS, sample: '0, status: st, rate: rate_u,
			channels: ch_u, bits: bits_u, last: 1'b1};
		push.p0 = accept && (smp_v || end_of_file);
		push.p1 = accept && smp_v && end_of_file;
		push.r0 = smp_v ? smp_res : st_res;
		push.r1 = st_res;
	end

	// end of file returns to the reset state
	always_comb begin
		ph_d = ph_u;
		off_d = off_u;
		word_d = word_u;
		ctype_d = ctype_u;
		left_d = left_u;
		pad_d = pad_u;
		ch_d = ch_u;
		bits_d = bits_u;
		rate_d = rate_u;
		found_d = found_u;
		idx_d = idx_u;
		first_d = first_u;
		second_d = second_u;
		err_d = err_u;
		if (end_of_file) begin
			ph_d = PH_HDR;
			off_d = '0;
			word_d = '0;
			ctype_d = CT_OTHER;
			left_d = '0;
			pad_d = 1'b0;
			ch_d = DEF_CHANNELS;
			bits_d = DEF_BITS;
			rate_d = DEF_RATE;
			found_d = 1'b0;
			idx_d = '0;
			first_d = '0;
			second_d = '0;
			err_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR;
			off_q <= '0;
			word_q <= '0;
			ctype_q <= CT_OTHER;
			left_q <= '0;
			pad_q <= 1'b0;
			ch_q <= DEF_CHANNELS;
			bits_q <= DEF_BITS;
			rate_q <= DEF_RATE;
			found_q <= 1'b0;
			idx_q <= '0;
			first_q <= '0;
			second_q <= '0;
			err_q <= ST_OK;
			fs_q <= DEF_FRAME;
		end else begin
			fs_q <= fs_prod;
			if (accept) begin
				ph_q <= ph_d;
				off_q <= off_d;
				word_q <= word_d;
				ctype_q <= ctype_d;
				left_q <= left_d;
				pad_q <= pad_d;
				ch_q <= ch_d;
				bits_q <= bits_d;
				rate_q <= rate_d;
				found_q <= found_d;
				idx_q <= idx_d;
				first_q <= first_d;
				second_q <= second_d;
				err_q <= err_d;
			end
		end
	end

endmodule

[rtl/core/wpsd_result_queue.sv]
// Result queue: takes up to two results per cycle from the parser, delivers one
// per cycle on the output handshake. Depends on wpsd_pkg.
module wpsd_result_queue import wpsd_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  head
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

	res_t            ent_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q, wr1, wr2, rd_n;
	logic [CntW-1:0] cnt_q;
	logic            pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign room = (cnt_q <= CntW'(Depth - 2));
	assign head = ent_q[rd_q];
	assign wr1 = (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
	assign wr2 = (wr1 == LastIdx) ? '0 : wr1 + PtrW'(1);
	assign rd_n = (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);

	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			if (push.p0 && wr_q == PtrW'(i)) ent_q[i] <= push.r0;
			if (push.p1 && wr1 == PtrW'(i)) ent_q[i] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.p1) wr_q <= wr2;
			else if (push.p0) wr_q <= wr1;
			if (pop) rd_q <= rd_n;
			cnt_q <= cnt_q + CntW'(push.p0) + CntW'(push.p1) - CntW'(pop);
		end
	end

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.p1 |-> push.p0) else $error("second result pushed without first");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.p0 |-> cnt_q <= CntW'(Depth - 2)) else $error("push without room");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth)) else $error("queue count out of range");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push.p0 |=> cnt_q == $past(cnt_q) - CntW'(1))
		else $error("queue count did not drop on pop");

endmodule

[rtl/core/wav_pcm_stream_decoder_top.sv]
// Top level of the WAV PCM stream decoder: parser feeding a result queue.
// Depends on wpsd_pkg, wpsd_parser and wpsd_result_queue.
//
// Takes a RIFF/WAVE file one byte per transaction and returns mono PCM samples
// (8- or 16-bit, stereo summed, units of 2^-16 full scale) plus one status
// result on the byte flagged end_of_file, after which the block is back in its
// reset state for the next file. Throughput is one byte per clock while
// in_ready is high: each byte is parsed in the cycle it is taken. A byte makes
// at most two results (a final sample and the status); the result queue of
// Depth entries drains one result per clock while out_ready is high, and
// in_ready drops while fewer than two entries are free. Results enter the queue at
// the accepting edge. The fmt chunk must precede the data chunk.
module wav_pcm_stream_decoder_top import wpsd_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               end_of_file,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic signed [16:0] sample,
	output logic [2:0]         status,
	output logic [31:0]        sample_rate,
	output logic [15:0]        num_channels,
	output logic [15:0]        sample_bits,
	output logic               last
);

	push_t push;
	res_t  head;
	logic  accept;

	assign accept = in_valid && in_ready;

	wpsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.end_of_file(end_of_file),
		.push       (push)
	);

	wpsd_result_queue #(
		.Depth(Depth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign kind = head.kind;
	assign sample = head.sample;
	assign status = head.status;
	assign sample_rate = head.rate;
	assign num_channels = head.channels;
	assign sample_bits = head.bits;
	assign last = head.last;

endmodule
